// ===== src/xhfp_pkg.sv =====
package xhfp_pkg;

   localparam logic [8:0] MaxMessage = 9'd255;

   localparam logic [15:0] TimeoutTicksReset = 16'd200;
   localparam logic [7:0]  PayloadLimitReset = 8'd251;

   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_TIMEOUT_TICKS = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PAYLOAD_LIMIT = 1'd1;

   localparam logic [7:0] CharX  = 8'h78;
   localparam logic [7:0] CharCr = 8'h0d;
   localparam logic [7:0] CharLf = 8'h0a;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_HEADER = 2'd1,
      PHASE_BODY   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      KIND_DATA       = 3'd0,
      KIND_FRAME_OK   = 3'd1,
      KIND_ODD_LENGTH = 3'd2,
      KIND_TOO_LONG   = 3'd3,
      KIND_TIMEOUT    = 3'd4,
      KIND_BAD_HEADER = 3'd5
   } kind_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  header_position;
      logic [3:0]  held_nibble;
      logic        first_digit_bad;
      logic [9:0]  char_count;
      logic [15:0] tick_count;
   } state_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  payload_limit;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data_byte;
      logic [8:0] byte_index;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   localparam state_type StateReset = '{
      phase:           PHASE_IDLE,
      header_position: 3'd0,
      held_nibble:     4'd0,
      first_digit_bad: 1'b0,
      char_count:      10'd0,
      tick_count:      16'd0
   };

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic logic [7:0] header_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd1: c = 8'h64;
         3'd2: c = 8'h61;
         3'd3: c = 8'h74;
         3'd4: c = 8'h61;
         default: c = 8'h3d;
      endcase
      return c;
   endfunction

endpackage

// ===== src/xhfp_req_if.sv =====
interface xhfp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink (input valid, input action, input rx_byte, output ready);
endinterface

// ===== src/xhfp_rsp_if.sv =====
interface xhfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data_byte;
   logic [8:0] byte_index;

   modport source (output valid, output kind, output data_byte, output byte_index,
                   input ready);
   modport sink (input valid, input kind, input data_byte, input byte_index,
                 output ready);
endinterface

// ===== src/xhfp_step.sv =====
module xhfp_step (
   input  xhfp_pkg::state_type  state_ff,
   input  xhfp_pkg::cfg_type    cfg,
   input  logic                 action,
   input  logic [7:0]           rx_byte,
   output xhfp_pkg::state_type  state_in,
   output xhfp_pkg::result_type result
);

   logic                 active;
   logic [8:0]           eff_limit;
   logic [8:0]           pair_count;
   logic [2:0]           hdr_pos;
   logic                 hdr_bad;
   xhfp_pkg::hex_type    hex;
   logic [7:0]           pair_byte;

   assign active     = (state_ff.phase == xhfp_pkg::PHASE_HEADER) ||
                       (state_ff.phase == xhfp_pkg::PHASE_BODY);
   assign eff_limit  = ({1'b0, cfg.payload_limit} < xhfp_pkg::MaxMessage) ?
                       {1'b0, cfg.payload_limit} : xhfp_pkg::MaxMessage;
   assign pair_count = state_ff.char_count[9:1];
   assign hdr_pos    = (state_ff.header_position < 3'd1 || state_ff.header_position > 3'd5) ?
                       3'd5 : state_ff.header_position;
   assign hdr_bad    = state_ff.first_digit_bad || (rx_byte != xhfp_pkg::header_char(hdr_pos));
   assign hex        = xhfp_pkg::hex_decode(rx_byte);

   always_comb begin
      if (state_ff.first_digit_bad) begin
         pair_byte = 8'd0;
      end else if (!hex.ok) begin
         pair_byte = {4'd0, state_ff.held_nibble};
      end else begin
         pair_byte = {state_ff.held_nibble, hex.value};
      end
   end

   always_comb begin
      state_in          = state_ff;
      result.valid      = 1'b0;
      result.kind       = xhfp_pkg::KIND_DATA;
      result.data_byte  = 8'd0;
      result.byte_index = pair_count;

      if (action) begin
         if (active) begin
            if (state_ff.tick_count >= cfg.timeout_ticks) begin
               state_in     = xhfp_pkg::StateReset;
               result.valid = 1'b1;
               result.kind  = xhfp_pkg::KIND_TIMEOUT;
            end else begin
               state_in.tick_count = state_ff.tick_count + 16'd1;
            end
         end
      end else begin
         case (state_ff.phase)
            xhfp_pkg::PHASE_HEADER: begin
               if (hdr_pos == 3'd5) begin
                  state_in = xhfp_pkg::StateReset;
                  if (hdr_bad) begin
                     result.valid      = 1'b1;
                     result.kind       = xhfp_pkg::KIND_BAD_HEADER;
                     result.byte_index = 9'd0;
                  end else begin
                     state_in.phase      = xhfp_pkg::PHASE_BODY;
                     state_in.tick_count = state_ff.tick_count;
                  end
               end else begin
                  state_in.header_position = hdr_pos + 3'd1;
                  state_in.first_digit_bad = hdr_bad;
               end
            end
            xhfp_pkg::PHASE_BODY: begin
               if (rx_byte == xhfp_pkg::CharCr || rx_byte == xhfp_pkg::CharLf) begin
                  state_in     = xhfp_pkg::StateReset;
                  result.valid = 1'b1;
                  if (state_ff.char_count[0]) begin
                     result.kind = xhfp_pkg::KIND_ODD_LENGTH;
                  end else if (pair_count > eff_limit) begin
                     result.kind = xhfp_pkg::KIND_TOO_LONG;
                  end else begin
                     result.kind = xhfp_pkg::KIND_FRAME_OK;
                  end
               end else begin
                  state_in.char_count = (state_ff.char_count == 10'd1023) ?
                                        10'd1022 : state_ff.char_count + 10'd1;
                  if (!state_ff.char_count[0]) begin
                     state_in.held_nibble     = hex.value;
                     state_in.first_digit_bad = !hex.ok;
                  end else if (pair_count < eff_limit) begin
                     result.valid     = 1'b1;
                     result.data_byte = pair_byte;
                  end
               end
            end
            default: begin
               if (rx_byte == xhfp_pkg::CharX) begin
                  state_in                 = xhfp_pkg::StateReset;
                  state_in.phase           = xhfp_pkg::PHASE_HEADER;
                  state_in.header_position = 3'd1;
               end
            end
         endcase
      end
   end

endmodule

// ===== src/xdata_hex_frame_parser.sv =====
// Frame decoder for ASCII hex lines of the form "xdata=" followed by hex pairs.
// The request channel carries one event per transfer: a received character
// (action 0, rx_byte) or one time tick (action 1). The response channel
// carries data bytes with their index and one status at the end of each frame
// (ok, odd length, too long, timeout or bad header). Data of a frame that
// does not end with "frame ok" must be discarded by the receiver.
// The two configuration registers are written through csr_we, csr_index and
// csr_wdata; the user must write them only while the block is idle, which
// the block itself does not enforce. Index 0 is the timeout in ticks and
// index 1 is the payload limit. A request is taken into an input register,
// decoded by the step logic and its response, if any, is placed in the
// response register. One request is accepted every cycle while the receiver
// does not stall.
// When the receiver stalls, the response register holds its contents and the
// input register keeps one further request; ready drops only when both are
// full. Synchronous reset empties both registers, returns the decoder to idle
// and loads the configuration defaults of 200 ticks and 251 bytes.
module xdata_hex_frame_parser (
   input  logic                                   clock,
   input  logic                                   reset,
   xhfp_req_if.sink                               req_ch,
   xhfp_rsp_if.source                             rsp_ch,
   input  logic                                   csr_we,
   input  logic [xhfp_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [xhfp_pkg::CsrDataWidth-1:0]      csr_wdata
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  in_action_ff;
   logic [7:0]            in_byte_ff;
   logic                  advance;

   xhfp_pkg::state_type   state_ff;
   xhfp_pkg::state_type   state_in;
   xhfp_pkg::state_type   step_state;
   xhfp_pkg::cfg_type     cfg_ff;
   xhfp_pkg::cfg_type     cfg_in;
   xhfp_pkg::result_type  step_result;
   xhfp_pkg::result_type  rsp_ff;
   xhfp_pkg::result_type  rsp_in;

   assign advance      = in_valid_ff && (!rsp_ff.valid || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = (req_ch.valid && req_ch.ready) || (in_valid_ff && !advance);

   xhfp_step u_step (
      .state_ff (state_ff),
      .cfg      (cfg_ff),
      .action   (in_action_ff),
      .rx_byte  (in_byte_ff),
      .state_in (step_state),
      .result   (step_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            xhfp_pkg::CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata[15:0];
            xhfp_pkg::CSR_PAYLOAD_LIMIT: cfg_in.payload_limit = csr_wdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_in   = rsp_ff;
      if (advance) begin
         state_in = step_state;
         rsp_in   = step_result;
      end else if (rsp_ch.ready) begin
         rsp_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                <= 1'b0;
         state_ff                   <= xhfp_pkg::StateReset;
         cfg_ff.timeout_ticks       <= xhfp_pkg::TimeoutTicksReset;
         cfg_ff.payload_limit       <= xhfp_pkg::PayloadLimitReset;
         rsp_ff.valid               <= 1'b0;
      end else begin
         in_valid_ff                <= in_valid_in;
         state_ff                   <= state_in;
         cfg_ff                     <= cfg_in;
         rsp_ff                     <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_action_ff <= req_ch.action;
         in_byte_ff   <= req_ch.rx_byte;
      end
   end

   assign rsp_ch.valid      = rsp_ff.valid;
   assign rsp_ch.kind       = rsp_ff.kind;
   assign rsp_ch.data_byte  = rsp_ff.data_byte;
   assign rsp_ch.byte_index = rsp_ff.byte_index;

   a_status_has_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && rsp_ff.kind != xhfp_pkg::KIND_DATA) |-> (rsp_ff.data_byte == 8'd0))
      else $error("status response carries a nonzero data byte");

   a_status_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && step_result.valid && step_result.kind != xhfp_pkg::KIND_DATA)
      |=> (state_ff.phase == xhfp_pkg::PHASE_IDLE))
      else $error("decoder did not return to idle after a frame status");

   a_data_within_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.valid && rsp_ff.kind == xhfp_pkg::KIND_DATA)
      |-> (rsp_ff.byte_index < {1'b0, cfg_ff.payload_limit} &&
           rsp_ff.byte_index < xhfp_pkg::MaxMessage))
      else $error("data byte index beyond the payload limit");

   a_header_position_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == xhfp_pkg::PHASE_HEADER)
      |-> (state_ff.header_position >= 3'd1 && state_ff.header_position <= 3'd5))
      else $error("header position out of range");

endmodule
